// File: rtl/core/rhc_pkg.sv
// Shared types for the RGB to HSV/HSL converter.
// Holds the channel payload structs and the divider pipeline word; no dependencies.
package rhc_pkg;

   localparam int QuotBits = 16;   // quotient bits produced by the divider
   localparam int DivSteps = 16;   // one quotient bit per pipeline stage

   typedef struct packed {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [8:0]  level;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] mx;
      logic [7:0] mn;
      logic       red_max;
      logic       green_max;
   } front_type;

   // Hue and sat division words, each {partial remainder, dividend/quotient bits}.
   typedef struct packed {
      logic [23:0] hue_work;
      logic [7:0]  hue_div;
      logic [23:0] sat_work;
      logic [7:0]  sat_div;
      logic        zero;
      logic [8:0]  level;
   } div_type;

endpackage

// File: rtl/core/rhc_div_step.sv
// One restoring-division step for the hue and saturation quotients.
// Depends on rhc_pkg for the divider word.
module rhc_div_step (
   input  rhc_pkg::div_type din,
   output rhc_pkg::div_type dout
);
   import rhc_pkg::*;

   logic [8:0] hue_trial;
   logic [8:0] sat_trial;
   logic       hue_bit;
   logic       sat_bit;

   always_comb begin
      hue_trial = din.hue_work[23:15];
      sat_trial = din.sat_work[23:15];
      hue_bit   = (hue_trial >= {1'b0, din.hue_div});
      sat_bit   = (sat_trial >= {1'b0, din.sat_div});
      dout      = din;
      dout.hue_work[23:16] = hue_bit ? 8'(hue_trial - {1'b0, din.hue_div})
                                     : hue_trial[7:0];
      dout.hue_work[15:0]  = {din.hue_work[14:0], hue_bit};
      dout.sat_work[23:16] = sat_bit ? 8'(sat_trial - {1'b0, din.sat_div})
                                     : sat_trial[7:0];
      dout.sat_work[15:0]  = {din.sat_work[14:0], sat_bit};
   end

endmodule

// File: rtl/core/rgb_to_hsv_hsl_converter_top.sv
// Pipelined RGB to HSV/HSL pixel converter, top level.
// Depends on rhc_pkg and rhc_div_step.
//
//   channel | direction | payload          | handshake
//   req     | in        | mode, r, g, b    | req_valid / req_stall
//   rsp     | out       | hue, sat, level  | rsp_valid / rsp_stall
//
// One pixel enters per clock unless req_stall holds it; the pipeline has one
// stage for max/min, one for the numerators and sixteen for the bit-serial
// dividers (one quotient bit per stage). Synchronous reset clears all valid
// bits. A stall holds only the stages that are full up to the first bubble,
// so empty stages keep filling while the result transfer is held.
module rgb_to_hsv_hsl_converter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rhc_pkg::rsp_type rsp_data
);
   import rhc_pkg::*;

   localparam int NumStages = DivSteps + 2;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages:0]   adv;

   front_type front_ff, front_in;
   div_type   div_ff [DivSteps+1];
   div_type   div_in [DivSteps+1];

   logic [7:0]  delta;
   logic [8:0]  sum;
   logic [7:0]  den;
   logic [10:0] k;

   // a stage moves if it is empty or the next stage moves
   assign adv[NumStages] = !rsp_stall;
   genvar gi;
   generate
      for (gi = 0; gi < NumStages; gi++) begin : g_adv
         assign adv[gi] = !valid_ff[gi] || adv[gi+1];
      end
   endgenerate

   assign req_stall = !adv[0];

   always_comb begin
      valid_in = valid_ff;
      valid_in[0] = req_valid;
      for (int i = 1; i < NumStages; i++) valid_in[i] = valid_ff[i-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumStages; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   // max / min and winning channel
   always_comb begin
      front_in.mode  = req_data.mode;
      front_in.red   = req_data.red;
      front_in.green = req_data.green;
      front_in.blue  = req_data.blue;
      front_in.red_max   = (req_data.red >= req_data.green) &&
                           (req_data.red >= req_data.blue);
      front_in.green_max = !front_in.red_max && (req_data.green >= req_data.blue);
      if (front_in.red_max) begin
         front_in.mx = req_data.red;
      end else if (front_in.green_max) begin
         front_in.mx = req_data.green;
      end else begin
         front_in.mx = req_data.blue;
      end
      front_in.mn = req_data.red;
      if (req_data.green < front_in.mn) front_in.mn = req_data.green;
      if (req_data.blue < front_in.mn) front_in.mn = req_data.blue;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) front_ff <= front_in;
   end

   // numerators and divisors; hue numerator is 3840 * k
   always_comb begin
      delta = front_ff.mx - front_ff.mn;
      sum   = {1'b0, front_ff.mx} + {1'b0, front_ff.mn};
      den   = (sum >= 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
      if (front_ff.red_max) begin
         if (front_ff.green >= front_ff.blue) begin
            k = {3'b0, 8'(front_ff.green - front_ff.blue)};
         end else begin
            k = 11'(11'(delta) * 11'd6) - {3'b0, 8'(front_ff.blue - front_ff.green)};
         end
      end else if (front_ff.green_max) begin
         k = 11'({3'b0, delta} << 1) + {3'b0, front_ff.blue} - {3'b0, front_ff.red};
      end else begin
         k = 11'({3'b0, delta} << 2) + {3'b0, front_ff.red} - {3'b0, front_ff.green};
      end
      div_in[0].hue_work = {1'b0, k, 12'b0} - {5'b0, k, 8'b0};
      div_in[0].hue_div  = delta;
      div_in[0].sat_work = {delta, 16'b0} - {16'b0, delta};
      div_in[0].sat_div  = front_ff.mode ? den : front_ff.mx;
      div_in[0].zero     = (delta == 8'd0);
      div_in[0].level    = front_ff.mode ? sum : {front_ff.mx, 1'b0};
   end

   generate
      for (gi = 1; gi <= DivSteps; gi++) begin : g_div
         rhc_div_step u_step (
            .din  (div_ff[gi-1]),
            .dout (div_in[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DivSteps; i++) begin
         if (adv[i+1]) div_ff[i] <= div_in[i];
      end
   end

   assign rsp_valid = valid_ff[NumStages-1];

   always_comb begin
      rsp_data.level = div_ff[DivSteps].level;
      if (div_ff[DivSteps].zero) begin
         rsp_data.hue        = 15'd0;
         rsp_data.saturation = 16'd0;
      end else begin
         rsp_data.hue        = div_ff[DivSteps].hue_work[14:0];
         rsp_data.saturation = div_ff[DivSteps].sat_work[QuotBits-1:0];
      end
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the RGB to HSV/HSL pixel converter: directed table, then random pixels.
// Depends on rhc_pkg and rgb_to_hsv_hsl_converter_top; checks against a local predictor.
module tb;
   import rhc_pkg::*;

   localparam logic MODE_HSV = 1'b0;
   localparam logic MODE_HSL = 1'b1;
   localparam int   RANDOM_PIXELS = 1430;
   localparam int   CYCLE_LIMIT = 200000;

   typedef struct {
      req_type pix;
      logic    typed;
      rsp_type want;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type pending_q[$];
   int      mismatches = 0;
   int      cycles = 0;
   int      rsp_wait;
   int      rsp_draw;

   rgb_to_hsv_hsl_converter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type convert_pixel(req_type p);
      int      r, g, b, hi, lo, delta, n, den;
      rsp_type o;
      r = p.red;
      g = p.green;
      b = p.blue;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      n = 0;
      if (delta != 0) begin
         if (hi == r) begin
            n = 3840 * (g - b);
            if (n < 0) n += 23040 * delta;
         end else if (hi == g) begin
            n = 3840 * (b - r) + 7680 * delta;
         end else begin
            n = 3840 * (r - g) + 15360 * delta;
         end
         n = (n / delta) % 23040;
      end
      o.hue = n[14:0];
      if (p.mode == MODE_HSV) begin
         o.saturation = (hi == 0) ? 16'd0 : 16'((delta * 65535) / hi);
         o.level = 9'(2 * hi);
      end else begin
         den = 255 - (((hi + lo) >= 255) ? hi + lo - 255 : 255 - hi - lo);
         o.level = 9'(hi + lo);
         if (delta == 0 || den == 0) begin
            o.saturation = 16'd0;
            o.hue = 15'd0;
         end else begin
            n = (delta * 65535) / den;
            o.saturation = (n > 65535) ? 16'hFFFF : 16'(n);
         end
      end
      return o;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic req_type pixel(logic m, int r, int g, int b);
      req_type p;
      p.mode = m;
      p.red = 8'(r);
      p.green = 8'(g);
      p.blue = 8'(b);
      return p;
   endfunction

   function automatic rsp_type out(int h, int s, int l);
      rsp_type o;
      o.hue = 15'(h);
      o.saturation = 16'(s);
      o.level = 9'(l);
      return o;
   endfunction

   // Sender: hold payload while stalled, random gap per pixel; valid stays up
   // across back-to-back transfers.
   task automatic send_pixel(req_type p, logic typed, rsp_type want);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      pending_q.push_back(typed ? want : convert_pixel(p));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver: check every transfer, then draw a fresh stall length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               if (rsp_data.hue != pending_q[0].hue)
                  report("hue", rsp_data.hue, pending_q[0].hue);
               if (rsp_data.saturation != pending_q[0].saturation)
                  report("saturation", rsp_data.saturation, pending_q[0].saturation);
               if (rsp_data.level != pending_q[0].level)
                  report("level", rsp_data.level, pending_q[0].level);
               void'(pending_q.pop_front());
            end
            rsp_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            if (rsp_draw == 0) begin
               rsp_wait <= 0;
               rsp_stall <= 1'b0;
            end else begin
               rsp_wait <= rsp_draw - 1;
               rsp_stall <= 1'b1;
            end
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type row;
      req_type p;
      int      k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      // Extremes, grays, ties and each hue sector.
      rows.push_back('{pixel(MODE_HSV, 0, 0, 0), 1'b1, out(0, 0, 0)});
      rows.push_back('{pixel(MODE_HSL, 0, 0, 0), 1'b1, out(0, 0, 0)});
      rows.push_back('{pixel(MODE_HSV, 255, 255, 255), 1'b1, out(0, 0, 510)});
      rows.push_back('{pixel(MODE_HSL, 255, 255, 255), 1'b1, out(0, 0, 510)});
      rows.push_back('{pixel(MODE_HSV, 255, 0, 0), 1'b1, out(0, 65535, 510)});
      rows.push_back('{pixel(MODE_HSL, 255, 0, 0), 1'b1, out(0, 65535, 255)});
      rows.push_back('{pixel(MODE_HSV, 0, 255, 0), 1'b1, out(7680, 65535, 510)});
      rows.push_back('{pixel(MODE_HSV, 0, 0, 255), 1'b1, out(15360, 65535, 510)});
      rows.push_back('{pixel(MODE_HSL, 0, 255, 0), 1'b1, out(7680, 65535, 255)});
      rows.push_back('{pixel(MODE_HSL, 0, 0, 255), 1'b1, out(15360, 65535, 255)});
      rows.push_back('{pixel(MODE_HSV, 128, 128, 128), 1'b1, out(0, 0, 256)});
      rows.push_back('{pixel(MODE_HSL, 128, 128, 128), 1'b1, out(0, 0, 256)});
      rows.push_back('{pixel(MODE_HSV, 255, 255, 0), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSV, 0, 255, 255), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSV, 255, 0, 255), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSL, 255, 0, 1), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSV, 255, 0, 1), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSL, 1, 0, 0), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSL, 255, 254, 255), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSV, 1, 0, 0), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSL, 200, 100, 50), 1'b0, '0});
      rows.push_back('{pixel(MODE_HSV, 50, 100, 200), 1'b0, '0});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         row = rows[i];
         send_pixel(row.pix, row.typed, row.want);
      end
      for (k = 0; k < RANDOM_PIXELS; k++) begin
         p.mode = 1'($urandom);
         p.red = 8'($urandom);
         p.green = 8'($urandom);
         p.blue = 8'($urandom);
         // Bias some pixels toward exact and near ties between channels.
         case ($urandom_range(0, 5))
            0: p.green = p.red;
            1: p.blue = p.green;
            2: p.blue = 8'(p.red + $urandom_range(0, 2));
            default: ;
         endcase
         send_pixel(p, 1'b0, '0);
         if (k == RANDOM_PIXELS / 2) begin
            // drain the pipe before sending more
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_q.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
